// ===== hdl/ipv4_prefix_bitmap_top_assert.svh =====
// assertion macros shared by the bitmap block
`ifndef IPV4_PREFIX_BITMAP_TOP_ASSERT_SVH
`define IPV4_PREFIX_BITMAP_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IPB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define IPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ipb_pkg.sv =====
// shared types and constants for the prefix bitmap block
`timescale 1ns / 1ps

package ipb_pkg;

  localparam int ADDR_W      = 32;
  localparam int PLEN_W      = 7;
  localparam int MAX_PLEN    = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } ipb_op_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic dec1;
    logic dec2;
    logic dec3;
    logic fill_step;
    logic look_rd;
    logic hit_load;
    logic out_load;
  } ipb_cmd_t;

  // datapath to controller
  typedef struct packed {
    ipb_op_t op;
    logic    skip_fill;
    logic    clr_last;
    logic    fill_last;
    logic    out_free;
  } ipb_stat_t;

endpackage

// ===== hdl/ipv4_prefix_bitmap_top.sv =====
// lookup: decode, memory read, hit capture, result beat; one item at a time
// add: decode, then fill with one read-modify-write of the bitmap memory per cycle
// clear: one word zeroed per cycle over all 2^MAP_INDEX_BITS / WORD_BITS words
// rst is synchronous, active high; after it a clearing pass over all
// 2^MAP_INDEX_BITS / WORD_BITS words (262144 by default) runs with s_axis_tready low
`timescale 1ns / 1ps

`include "ipv4_prefix_bitmap_top_assert.svh"

module ipv4_prefix_bitmap_top
  import ipb_pkg::*;
#(
  parameter int MAP_INDEX_BITS = 24,
  parameter int WORD_BITS      = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // address[31:0], prefix_length[38:32]
  input  logic [1:0]             s_axis_tuser,   // operation[1:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // hit[0]
  output logic                   m_axis_tuser    // status[0]
);

  ipb_cmd_t  cmd;
  ipb_stat_t stat;
  logic      out_hit;

  ipb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ipb_dp #(
    .MAP_INDEX_BITS (MAP_INDEX_BITS),
    .WORD_BITS      (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (s_axis_tuser),
    .in_address (s_axis_tdata[ADDR_W-1:0]),
    .in_plen    (s_axis_tdata[ADDR_W +: PLEN_W]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_hit    (out_hit),
    .out_status (m_axis_tuser)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-1){1'b0}}, out_hit};

  `IPB_ASSERT_NEXT(a_busy_after_beat, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
  `IPB_ASSERT_IMPLY(a_clear_after_reset, $fell(rst), !s_axis_tready, "ready before clearing pass")
  `IPB_ASSERT_IMPLY(a_reject_no_hit, m_axis_tvalid && m_axis_tuser, !m_axis_tdata[0], "hit on rejected add")

endmodule

// ===== hdl/ipb_ctrl.sv =====
// sequencer for clear, fill and lookup
`timescale 1ns / 1ps

module ipb_ctrl
  import ipb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ipb_stat_t stat,
  output ipb_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC1,
    ST_DEC2,
    ST_DEC3,
    ST_FILL,
    ST_DRAIN,
    ST_LOOK,
    ST_LOOKW,
    ST_DONE
  } state_t;

  state_t state, state_next;
  logic   init_pass, init_pass_next;

  always_comb begin
    state_next     = state;
    init_pass_next = init_pass;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          // the pass after reset gives no result
          state_next     = init_pass ? ST_IDLE : ST_DONE;
          init_pass_next = 1'b0;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DEC1;
        end
      end
      ST_DEC1: begin
        cmd.dec1 = 1'b1;
        case (stat.op)
          OP_CLEAR:  state_next = ST_CLEAR;
          OP_ADD:    state_next = stat.skip_fill ? ST_DONE : ST_DEC2;
          OP_LOOKUP: state_next = ST_DEC2;
          default:   state_next = ST_DONE;
        endcase
      end
      ST_DEC2: begin
        cmd.dec2   = 1'b1;
        state_next = ST_DEC3;
      end
      ST_DEC3: begin
        cmd.dec3   = 1'b1;
        state_next = (stat.op == OP_LOOKUP) ? ST_LOOK : ST_FILL;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_LOOK: begin
        cmd.look_rd = 1'b1;
        state_next  = ST_LOOKW;
      end
      ST_LOOKW: begin
        cmd.hit_load = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      init_pass <= 1'b1;
    end else begin
      state     <= state_next;
      init_pass <= init_pass_next;
    end
  end

endmodule

// ===== hdl/ipb_dp.sv =====
// bitmap memory, address split, fill masks and result register
`timescale 1ns / 1ps

module ipb_dp
  import ipb_pkg::*;
#(
  parameter int MAP_INDEX_BITS = 24,
  parameter int WORD_BITS      = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ipb_cmd_t                cmd,
  output ipb_stat_t               stat,
  input  logic [1:0]              in_op,
  input  logic [ADDR_W-1:0]       in_address,
  input  logic [PLEN_W-1:0]       in_plen,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit,
  output logic                    out_status
);

  localparam int MIB       = MAP_INDEX_BITS;
  localparam int MAP_WORDS = ((1 << MIB) + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = $clog2(MAP_WORDS);
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int CNT_W     = $clog2(WORD_BITS + 1);
  localparam int LEFT_W    = MIB + 1;
  // exact quotient by reciprocal: block < 2^MIB, shift MIB + OFF_W
  localparam int SHIFT     = MIB + OFF_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W   = MIB + 2;
  localparam int PROD_W    = MIB + RECIP_W;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  ipb_op_t             op_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [PLEN_W-1:0]   plen_q;
  logic [PROD_W-1:0]   prod;
  logic [WIDX_W-1:0]   wq;
  logic [OFF_W-1:0]    woff;
  logic [LEFT_W-1:0]   left;
  logic [WIDX_W-1:0]   clr_addr;
  logic                pipe_valid;
  logic [WIDX_W-1:0]   pipe_addr;
  logic [WORD_BITS-1:0] pipe_mask;
  logic [WORD_BITS-1:0] rdata;
  logic                res_hit;

  logic [MIB-1:0]       block;
  logic                 skip_fill;
  logic                 plen_bad;
  logic [PLEN_W-1:0]    sh;
  logic [LEFT_W-1:0]    cnt;
  logic [LEFT_W-1:0]    room;
  logic [MIB-1:0]       wbase;
  logic [OFF_W-1:0]     off_calc;
  logic [CNT_W-1:0]     avail;
  logic                 fill_last;
  logic [LEFT_W-1:0]    lim;
  logic [WORD_BITS-1:0] mask;
  logic                 clr_last;
  logic                 wr_en;
  logic [WIDX_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 rd_en;

  assign block     = addr_q[ADDR_W-1 -: MIB];
  assign skip_fill = plen_q > PLEN_W'(MIB);
  assign plen_bad  = plen_q > PLEN_W'(MAX_PLEN);
  assign sh        = PLEN_W'(MIB) - plen_q;
  assign cnt       = LEFT_W'(1) << sh;
  assign room      = (LEFT_W'(1) << MIB) - LEFT_W'(block);
  assign wbase     = MIB'(MIB'(wq) * MIB'(WORD_BITS));
  assign off_calc  = OFF_W'(block - wbase);
  assign avail     = CNT_W'(WORD_BITS) - CNT_W'(woff);
  assign fill_last = left <= LEFT_W'(avail);
  assign lim       = LEFT_W'(woff) + left;
  assign clr_last  = clr_addr == WIDX_W'(MAP_WORDS - 1);

  // bits from the current offset up to the word end, or to the fill end
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (OFF_W'(i) >= woff) && (!fill_last || LEFT_W'(i) < lim);
    end
  end

  assign wr_en   = cmd.clr_step | pipe_valid;
  assign wr_addr = cmd.clr_step ? clr_addr : pipe_addr;
  assign wr_data = cmd.clr_step ? '0 : (rdata | pipe_mask);
  assign rd_en   = cmd.fill_step | cmd.look_rd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[wq];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      pipe_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_last ? '0 : clr_addr + WIDX_W'(1);
      end
      pipe_valid <= cmd.fill_step;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= ipb_op_t'(in_op);
      addr_q <= in_address;
      plen_q <= in_plen;
    end
    if (cmd.dec1) begin
      prod <= PROD_W'(block) * PROD_W'(RECIP_W'(RECIP));
      left <= (cnt < room) ? cnt : room;
    end
    if (cmd.dec2) begin
      wq <= WIDX_W'(prod >> SHIFT);
    end
    if (cmd.dec3) begin
      woff <= off_calc;
    end
    if (cmd.fill_step) begin
      pipe_addr <= wq;
      pipe_mask <= mask;
      wq        <= wq + WIDX_W'(1);
      woff      <= '0;
      left      <= left - LEFT_W'(avail);
    end
    if (cmd.load) begin
      res_hit <= 1'b0;
    end else if (cmd.hit_load) begin
      res_hit <= rdata[woff];
    end
    if (cmd.out_load) begin
      out_hit    <= res_hit;
      out_status <= (op_q == OP_ADD) && plen_bad;
    end
  end

  assign stat.op        = op_q;
  assign stat.skip_fill = skip_fill;
  assign stat.clr_last  = clr_last;
  assign stat.fill_last = fill_last;
  assign stat.out_free  = !out_valid || out_ready;

endmodule
